// ===== src/greedy_box_suppression_assert.svh =====
// assertion macros for the greedy box suppression block
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define GBS_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define GBS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== src/gbs_pkg.sv =====
// shared types and constants for the greedy box suppression block
package gbs_pkg;

    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int INDEX_W   = 16;
    localparam int THRESH_W  = 10;
    localparam int AREA_W    = 2 * SIZE_W;
    localparam int UNION_W   = AREA_W + 1;
    localparam int PROD_W    = UNION_W + THRESH_W;
    localparam int EDGE_W    = COORD_W + 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd461;
    localparam logic [INDEX_W-1:0]  INDEX_MAX    = 16'hFFFF;

    // one stored box
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } box_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

// ===== src/greedy_box_suppression.sv =====
// greedy box suppression by intersection over union, top level
//
// Boxes come in on the input channel (in_valid/in_ready), one word per box,
// sorted by descending score; set_start opens a new set. Each box gives one
// result word on the output channel (out_valid/out_ready): keep flag, its
// index in the set (saturating at 65535) and store_full for a kept box that
// found the store full. The threshold register is written through cfg_wr_en/
// cfg_wr_data; write it only while the block is idle, as this is not enforced.
// A box is compared against every stored box in turn, and one box is in work
// at a time: the next box is taken only after the last has reached the
// output register. The scan of the kept-box memory reads one stored box per
// cycle through a single five-stage overlap pipeline.
// Reset empties the store, zeroes the set index and loads threshold 461.
// A result waits in the output register while the receiver stalls; the next
// box is accepted and scanned meanwhile and then holds until the register
// is free.
module greedy_box_suppression #(
    parameter int MAX_KEPT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [gbs_pkg::THRESH_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                set_start,
    input  logic signed [gbs_pkg::COORD_W-1:0]  box_x,
    input  logic signed [gbs_pkg::COORD_W-1:0]  box_y,
    input  logic [gbs_pkg::SIZE_W-1:0]          box_w,
    input  logic [gbs_pkg::SIZE_W-1:0]          box_h,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                keep,
    output logic [gbs_pkg::INDEX_W-1:0]         box_index,
    output logic                                store_full
);
    import gbs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and overlap datapath
    gbs_datapath #(
        .MAX_KEPT (MAX_KEPT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .set_start   (set_start),
        .box_x       (box_x),
        .box_y       (box_y),
        .box_w       (box_w),
        .box_h       (box_h),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .keep        (keep),
        .box_index   (box_index),
        .store_full  (store_full)
    );

    // checks
`include "greedy_box_suppression_assert.svh"
    `GBS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `GBS_ASSERT_SAME(a_finish_drained, cmd.finish, !status.pipe_busy, "finish with compares in flight")
    `GBS_ASSERT_SAME(a_issue_in_range, cmd.issue, !status.scan_done, "read past kept count")
    `GBS_ASSERT_NEXT(a_finish_shows_word, cmd.finish, out_valid, "result word not shown")

endmodule

// ===== src/gbs_ctrl.sv =====
// controller: sequences load, store scan, pipeline drain and result hand-off
module gbs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gbs_pkg::status_t status,
    output gbs_pkg::cmd_t    cmd
);
    import gbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_DRAIN;
                else
                    cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/gbs_datapath.sv =====
// datapath: box store, overlap pipeline, counters and result register
module gbs_datapath #(
    parameter int MAX_KEPT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gbs_pkg::cmd_t                       cmd,
    output gbs_pkg::status_t                    status,
    input  logic                                cfg_wr_en,
    input  logic [gbs_pkg::THRESH_W-1:0]        cfg_wr_data,
    input  logic                                set_start,
    input  logic signed [gbs_pkg::COORD_W-1:0]  box_x,
    input  logic signed [gbs_pkg::COORD_W-1:0]  box_y,
    input  logic [gbs_pkg::SIZE_W-1:0]          box_w,
    input  logic [gbs_pkg::SIZE_W-1:0]          box_h,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                keep,
    output logic [gbs_pkg::INDEX_W-1:0]         box_index,
    output logic                                store_full
);
    import gbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_KEPT);

    // configuration and per-set state
    logic [THRESH_W-1:0] thresh_reg;
    logic [CW-1:0]       kept_count_reg;
    logic [CW-1:0]       kept_count_next;
    logic [INDEX_W-1:0]  set_pos_reg;
    logic [INDEX_W-1:0]  set_pos_next;
    logic [INDEX_W-1:0]  index_reg;
    logic [INDEX_W-1:0]  index_next;
    logic [CW-1:0]       scan_idx_reg;

    // current box
    box_t                cur_reg;
    logic [AREA_W-1:0]   cur_area_reg;
    logic                suppress_reg;

    // store
    box_t                mem [MAX_KEPT];
    box_t                rd_reg;

    // pipeline
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [SIZE_W-1:0]   iw_reg, ih_reg, kw_reg, kh_reg;
    logic [AREA_W-1:0]   inter3_reg, karea_reg, inter4_reg, inter5_reg;
    logic [UNION_W-1:0]  union_reg;
    logic [PROD_W-1:0]   prod_reg;

    // result register
    logic                out_valid_reg;
    logic                keep_reg;
    logic                full_reg;
    logic [INDEX_W-1:0]  out_index_reg;

    // overlap stage signals
    logic signed [EDGE_W-1:0] ax, ay, ar, ab, bx, by, br, bb;
    logic signed [EDGE_W-1:0] lo_x, lo_y, hi_x, hi_y;
    logic signed [EDGE_W:0]   dx, dy;
    logic                     disjoint;
    logic                     fin_keep;
    logic                     fin_full;
    logic [PROD_W-1:0]        lhs;

    // index and counter updates at load
    always_comb
    begin
        index_next      = set_start ? '0 : set_pos_reg;
        set_pos_next    = (index_next == INDEX_MAX) ? index_next : index_next + 1'b1;
        kept_count_next = set_start ? '0 : kept_count_reg;
    end

    // finish decision
    assign fin_keep = !suppress_reg;
    assign fin_full = fin_keep && (kept_count_reg == COUNT_FULL);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= THRESH_RESET;
            kept_count_reg <= '0;
            set_pos_reg    <= '0;
            scan_idx_reg   <= '0;
            suppress_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                thresh_reg <= cfg_wr_data;
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.load)
            begin
                kept_count_reg <= kept_count_next;
                set_pos_reg    <= set_pos_next;
                scan_idx_reg   <= '0;
                suppress_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (v5_reg && (lhs > prod_reg))
                    suppress_reg <= 1'b1;
                if (cmd.finish && fin_keep && !fin_full)
                    kept_count_reg <= kept_count_reg + 1'b1;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // current box capture and its area
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg.x <= box_x;
            cur_reg.y <= box_y;
            cur_reg.w <= box_w;
            cur_reg.h <= box_h;
            index_reg <= index_next;
        end
        cur_area_reg <= cur_reg.w * cur_reg.h;
    end

    // store write on kept box and registered read during scan
    always_ff @(posedge clk)
    begin
        if (cmd.finish && fin_keep && !fin_full)
            mem[kept_count_reg[AW-1:0]] <= cur_reg;
        if (cmd.issue)
            rd_reg <= mem[scan_idx_reg[AW-1:0]];
    end

    // edges of both boxes
    always_comb
    begin
        ax = EDGE_W'(cur_reg.x);
        ay = EDGE_W'(cur_reg.y);
        ar = ax + $signed({2'b00, cur_reg.w});
        ab = ay + $signed({2'b00, cur_reg.h});
        bx = EDGE_W'(rd_reg.x);
        by = EDGE_W'(rd_reg.y);
        br = bx + $signed({2'b00, rd_reg.w});
        bb = by + $signed({2'b00, rd_reg.h});
        disjoint = (ax > br) || (ar < bx) || (ay > bb) || (ab < by);
        lo_x = (ax > bx) ? ax : bx;
        lo_y = (ay > by) ? ay : by;
        hi_x = (ar < br) ? ar : br;
        hi_y = (ab < bb) ? ab : bb;
        dx = (EDGE_W + 1)'(hi_x) - (EDGE_W + 1)'(lo_x);
        dy = (EDGE_W + 1)'(hi_y) - (EDGE_W + 1)'(lo_y);
    end

    // shifted intersection for the compare
    assign lhs = PROD_W'({inter5_reg, {THRESH_W{1'b0}}});

    // overlap pipeline: widths, areas, union, weighted union
    always_ff @(posedge clk)
    begin
        iw_reg     <= disjoint ? '0 : dx[SIZE_W-1:0];
        ih_reg     <= disjoint ? '0 : dy[SIZE_W-1:0];
        kw_reg     <= rd_reg.w;
        kh_reg     <= rd_reg.h;
        inter3_reg <= iw_reg * ih_reg;
        karea_reg  <= kw_reg * kh_reg;
        union_reg  <= UNION_W'(cur_area_reg) + UNION_W'(karea_reg) - UNION_W'(inter3_reg);
        inter4_reg <= inter3_reg;
        prod_reg   <= thresh_reg * union_reg;
        inter5_reg <= inter4_reg;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            keep_reg      <= fin_keep;
            full_reg      <= fin_full;
            out_index_reg <= index_reg;
        end
    end

    // status to controller
    always_comb
    begin
        status.scan_done = (scan_idx_reg == kept_count_reg);
        status.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign store_full = full_reg;
    assign box_index  = out_index_reg;

endmodule
